/* hw/rtl/rvt_pkg.sv */
// ============================================================================
// rvt_pkg: shared types and codes of the vector table
// Action and status codes, the entry record held by each cell and the
// search wave record passed from cell to cell.
// ============================================================================
package rvt_pkg;

    localparam int ACT_W   = 2;
    localparam int ST_W    = 2;
    localparam int ID_W    = 16;
    localparam int ADDR_W  = 64;
    localparam int USE_W   = 16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_REGISTER   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UNREGISTER = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACQUIRE    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE    = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_IN_USE    = 2'd3;

    // Use count bounds
    localparam logic signed [USE_W-1:0] USE_MAX = 16'sh7FFF;
    localparam logic signed [USE_W-1:0] USE_MIN = 16'sh8000;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [ADDR_W-1:0]        addr;
        logic signed [USE_W-1:0]  uses;
    } t_entry;

    // Wave moving down the chain, one cell per cycle
    typedef struct packed {
        logic                     active;    // wave present at this cell
        logic                     searching; // no cell has claimed the item yet
        logic                     shift;     // removal: pull entries down
        logic                     hit;       // a cell claimed the item
        logic [ST_W-1:0]          status;
        logic [ADDR_W-1:0]        addr;
        logic signed [USE_W-1:0]  cnt;
    } t_wave;

endpackage

/* hw/rtl/rvt_cell.sv */
// ============================================================================
// rvt_cell: one table slot
// Holds one entry, checks the passing wave against it, applies the action
// when it is the first match and hands the wave on to the next slot.
// ============================================================================
module rvt_cell #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX           = 0
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [rvt_pkg::ACT_W-1:0]                i_action,
    input  logic [rvt_pkg::ID_W-1:0]                 i_vector_id,
    input  logic [rvt_pkg::ADDR_W-1:0]               i_vector_address,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]       i_entry_count,
    input  rvt_pkg::t_wave                           i_wave,
    input  rvt_pkg::t_entry                          i_right_entry,
    output rvt_pkg::t_wave                           o_wave,
    output rvt_pkg::t_entry                          o_entry
);
    import rvt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES+1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    t_entry r_entry, n_entry;
    t_wave  r_wave, n_wave;
    logic   w_in_table;
    logic   w_match;

    assign w_in_table = (MY_IDX < i_entry_count);

    always_comb begin
        unique case (i_action)
            ACT_REGISTER:   w_match = (MY_IDX == i_entry_count);
            ACT_UNREGISTER: w_match = w_in_table && (r_entry.addr == i_vector_address);
            ACT_ACQUIRE:    w_match = w_in_table && (r_entry.id == i_vector_id);
            ACT_RELEASE:    w_match = w_in_table && (r_entry.id == i_vector_id);
            default:        w_match = 1'b0;
        endcase
    end

    always_comb begin
        n_entry = r_entry;
        n_wave  = i_wave;
        if (i_wave.active) begin
            if (i_wave.shift) begin
                n_entry = i_right_entry;
            end else if (i_wave.searching && w_match) begin
                n_wave.searching = 1'b0;
                n_wave.hit       = 1'b1;
                n_wave.status    = ST_OK;
                unique case (i_action)
                    ACT_REGISTER: begin
                        n_entry.id   = i_vector_id;
                        n_entry.addr = i_vector_address;
                        n_entry.uses = '0;
                    end
                    ACT_UNREGISTER: begin
                        if (r_entry.uses > 0) begin
                            n_wave.status = ST_IN_USE;
                        end else begin
                            n_wave.shift = 1'b1;
                            n_entry      = i_right_entry;
                        end
                    end
                    ACT_ACQUIRE: begin
                        if (r_entry.uses != USE_MAX) begin
                            n_entry.uses = r_entry.uses + 16'sd1;
                        end
                        n_wave.addr = r_entry.addr;
                    end
                    ACT_RELEASE: begin
                        if (r_entry.uses != USE_MIN) begin
                            n_entry.uses = r_entry.uses - 16'sd1;
                        end
                        n_wave.cnt = n_entry.uses;
                    end
                    default: begin
                        n_wave.status = ST_NOT_FOUND;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_wave.active <= 1'b0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave  = r_wave;
    assign o_entry = r_entry;

endmodule

/* hw/rtl/refcounted_vector_table_unit.sv */
// ============================================================================
// refcounted_vector_table_unit: reference counted vector table
// Ordered table of (id, address, use count) entries; register, unregister,
// acquire and release, each giving one result.
// ============================================================================
// Result: o_done is high for exactly one cycle.
// One item at a time: the search wave walks the cell chain one cell per
//   cycle; busy stays high until it leaves, and no new item is taken.
// Reset: synchronous, active low; clears the entry count and the control
//   state. Entry contents are not cleared and need no clearing pass.
// The receiver cannot stall: the result is shown once and taken that cycle.
module refcounted_vector_table_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rvt_pkg::ACT_W-1:0]         i_action,
    input  logic [rvt_pkg::ID_W-1:0]          i_vector_id,
    input  logic [rvt_pkg::ADDR_W-1:0]        i_vector_address,
    output logic                              o_done,
    output logic [rvt_pkg::ST_W-1:0]          o_status,
    output logic [rvt_pkg::ADDR_W-1:0]        o_found_address,
    output logic signed [rvt_pkg::USE_W-1:0]  o_count_after
);
    import rvt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES+1);

    // Command held steady while the wave is in the chain
    logic [ACT_W-1:0]  r_action;
    logic [ID_W-1:0]   r_vector_id;
    logic [ADDR_W-1:0] r_vector_address;

    logic [CNT_W-1:0]  r_entry_count, n_entry_count;
    logic              r_busy;
    t_wave             r_launch;     // wave entering cell 0

    t_wave  w_wave  [TABLE_ENTRIES];
    t_entry w_entry [TABLE_ENTRIES];
    t_entry w_right [TABLE_ENTRIES];
    t_wave  w_tail;                  // wave leaving the last cell
    logic   w_accept;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;
    assign w_tail   = w_wave[TABLE_ENTRIES-1];

    // ---- Cell chain --------------------------------------------------------
    // Each cell sees its own wave input and its right neighbor's entry,
    // which it copies during a removal shift.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        t_wave w_wave_in;

        if (g == 0) begin : g_head
            assign w_wave_in = r_launch;
        end else begin : g_body
            assign w_wave_in = w_wave[g-1];
        end

        if (g == TABLE_ENTRIES-1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_inner
            assign w_right[g] = w_entry[g+1];
        end

        rvt_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .IDX           (g)
        ) u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_action         (r_action),
            .i_vector_id      (r_vector_id),
            .i_vector_address (r_vector_address),
            .i_entry_count    (r_entry_count),
            .i_wave           (w_wave_in),
            .i_right_entry    (w_right[g]),
            .o_wave           (w_wave[g]),
            .o_entry          (w_entry[g])
        );
    end

    // ---- Entry count update when the wave leaves the chain -----------------
    always_comb begin
        n_entry_count = r_entry_count;
        if (w_tail.active && w_tail.hit) begin
            if (r_action == ACT_REGISTER) begin
                n_entry_count = r_entry_count + CNT_W'(1);
            end else if (r_action == ACT_UNREGISTER && w_tail.status == ST_OK) begin
                n_entry_count = r_entry_count - CNT_W'(1);
            end
        end
    end

    // ---- Control -----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // Fresh wave: nobody has claimed it, default result is a miss
        r_launch.searching <= 1'b1;
        r_launch.shift     <= 1'b0;
        r_launch.hit       <= 1'b0;
        r_launch.status    <= ST_NOT_FOUND;
        r_launch.addr      <= '0;
        r_launch.cnt       <= '0;
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_launch.active <= 1'b0;
            r_entry_count   <= '0;
            o_done          <= 1'b0;
        end else begin
            r_entry_count   <= n_entry_count;
            o_done          <= w_tail.active;
            r_launch.active <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.active) begin
                r_busy <= 1'b0;
            end
        end
    end

    // ---- Payload -----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action           <= i_action;
            r_vector_id        <= i_vector_id;
            r_vector_address   <= i_vector_address;
        end

        if (w_tail.active) begin
            // A register that no cell took means the table is full
            if (!w_tail.hit && r_action == ACT_REGISTER) begin
                o_status <= ST_FULL;
            end else begin
                o_status <= w_tail.status;
            end
            o_found_address <= w_tail.addr;
            o_count_after   <= w_tail.cnt;
        end
    end

endmodule

/* hw/rtl/rvt_checker.sv */
// ============================================================================
// rvt_checker: port-level checks of the vector table
// Watches the command handshake and the result strobe.
// ============================================================================
module rvt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_done,
    input logic [rvt_pkg::ST_W-1:0]          o_status,
    input logic [rvt_pkg::ADDR_W-1:0]        o_found_address,
    input logic signed [rvt_pkg::USE_W-1:0]  o_count_after
);
    import rvt_pkg::*;

    // An accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // The result comes out as the block frees up
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe while busy");

    // One result per item
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // A failed action returns no data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_found_address == '0 && o_count_after == '0)
        else $error("data returned with failing status");

endmodule

bind refcounted_vector_table_unit rvt_checker u_rvt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_found_address (o_found_address),
    .o_count_after   (o_count_after)
);
